>>> rtl/afit_pkg.sv
// ----------------------------------------------------------------------------
// afit_pkg
// Shared types and constants for the ack fault-injection rule table.
// ----------------------------------------------------------------------------
package afit_pkg;

    // number of rule entries, one cell each
    localparam int TABLE_ENTRIES = 8;

    // shares are in tenths; the visit count wraps at this value
    localparam int SHARE_LIMIT = 10;
    localparam logic [3:0] COUNT_LAST = 4'(SHARE_LIMIT - 1);

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } afit_op_e;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } afit_status_e;

    typedef enum logic [1:0] {
        VD_NONE         = 2'd0,
        VD_TIMEOUT      = 2'd1,
        VD_EXCEPTION    = 2'd2,
        VD_HDR_MISMATCH = 2'd3
    } afit_verdict_e;

    // fault kind codes; anything above the last has no slot
    localparam logic [1:0] KIND_TIMEOUT      = 2'd0;
    localparam logic [1:0] KIND_EXCEPTION    = 2'd1;
    localparam logic [1:0] KIND_HDR_MISMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] peer_address;
        logic [15:0] peer_port;
        logic        direction;
        logic [1:0]  fault_kind;
        logic [3:0]  share_tenths;
        logic        pick_mode;
    } afit_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] verdict;
    } afit_result_t;

    // carried from cell to cell along the chain
    typedef struct packed {
        logic       hit_seen;
        logic       free_seen;
        logic [1:0] status;
        logic [1:0] verdict;
    } afit_link_t;

endpackage

>>> rtl/afit_cell.sv
// ----------------------------------------------------------------------------
// afit_cell
// One rule entry: key match, free-slot claim and the per-entry operations.
// ----------------------------------------------------------------------------
module afit_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 eval,
    input  afit_pkg::afit_item_t cmd,
    input  logic                 any_hit,
    input  afit_pkg::afit_link_t link_in,
    output afit_pkg::afit_link_t link_out
);
    import afit_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] address_reg, address_next;
    logic [15:0] port_reg, port_next;
    logic        direction_reg, direction_next;
    logic [2:0]  present_reg, present_next;
    logic [11:0] shares_reg, shares_next;
    logic [2:0]  modes_reg, modes_next;
    logic [3:0]  count_reg, count_next;

    logic          key_match;
    logic          hit;
    logic          claim;
    logic          kind_ok;
    logic          kind_here;
    logic [3:0]    present_ext;
    logic [15:0]   shares_ext;
    logic [2:0]    kind_mask;
    logic [3:0]    share_old;
    logic [3:0]    s0, s1, s2;
    logic [5:0]    end1, end2, end3;
    logic [5:0]    cnt_ext;
    logic [6:0]    add_sum;
    logic [6:0]    upd_sum;
    logic [11:0]   shares_set;
    logic [2:0]    modes_set;
    logic [2:0]    present_left;
    afit_status_e  my_status;
    afit_verdict_e my_verdict;

    always_comb
    begin
        key_match = valid_reg && (address_reg == cmd.peer_address)
                    && (port_reg == cmd.peer_port) && (direction_reg == cmd.direction);
        hit       = key_match && !link_in.hit_seen;
        claim     = !valid_reg && !link_in.free_seen;

        kind_ok     = (cmd.fault_kind <= KIND_HDR_MISMATCH);
        present_ext = {1'b0, present_reg};
        kind_here   = kind_ok && present_ext[cmd.fault_kind];
        kind_mask   = kind_ok ? (3'b001 << cmd.fault_kind) : 3'b000;
        shares_ext  = {4'd0, shares_reg};
        share_old   = shares_ext[{cmd.fault_kind, 2'b00} +: 4];

        // consecutive windows, one per present kind
        s0   = present_reg[0] ? shares_reg[3:0]  : 4'd0;
        s1   = present_reg[1] ? shares_reg[7:4]  : 4'd0;
        s2   = present_reg[2] ? shares_reg[11:8] : 4'd0;
        end1 = {2'b00, s0};
        end2 = end1 + {2'b00, s1};
        end3 = end2 + {2'b00, s2};

        cnt_ext = {2'b00, count_reg};
        add_sum = {1'b0, end3} + {3'b000, cmd.share_tenths};
        upd_sum = {1'b0, end3} - {3'b000, share_old} + {3'b000, cmd.share_tenths};

        shares_set = shares_reg;
        modes_set  = modes_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (kind_mask[k])
            begin
                shares_set[k*4 +: 4] = cmd.share_tenths;
                modes_set[k]         = cmd.pick_mode;
            end
        end
        present_left = present_reg & ~kind_mask;
    end

    always_comb
    begin
        valid_next     = valid_reg;
        address_next   = address_reg;
        port_next      = port_reg;
        direction_next = direction_reg;
        present_next   = present_reg;
        shares_next    = shares_reg;
        modes_next     = modes_reg;
        count_next     = count_reg;
        my_status      = ST_DONE;
        my_verdict     = VD_NONE;

        if (eval && hit)
        begin
            case (cmd.opcode)
                OP_CHECK:
                begin
                    if (cnt_ext < end1)
                        my_verdict = VD_TIMEOUT;
                    else if (cnt_ext < end2)
                        my_verdict = VD_EXCEPTION;
                    else if (cnt_ext < end3)
                        my_verdict = VD_HDR_MISMATCH;
                    count_next = (count_reg == COUNT_LAST) ? 4'd0 : count_reg + 4'd1;
                end
                OP_ADD:
                begin
                    if (!kind_ok || kind_here || add_sum >= 7'(SHARE_LIMIT))
                        my_status = ST_REJECT;
                    else
                    begin
                        shares_next  = shares_set;
                        modes_next   = modes_set;
                        present_next = present_reg | kind_mask;
                    end
                end
                OP_REMOVE:
                begin
                    if (!kind_here)
                        my_status = ST_NOT_FOUND;
                    else
                    begin
                        present_next = present_left;
                        if (present_left == 3'b000)
                            valid_next = 1'b0;
                    end
                end
                OP_UPDATE:
                begin
                    if (!kind_here)
                        my_status = ST_NOT_FOUND;
                    else if (upd_sum >= 7'(SHARE_LIMIT))
                        my_status = ST_REJECT;
                    else
                    begin
                        shares_next = shares_set;
                        modes_next  = modes_set;
                    end
                end
                default:
                begin
                    my_status = ST_NOT_FOUND;
                end
            endcase
        end
        else if (eval && claim && !any_hit && cmd.opcode == OP_ADD && kind_ok)
        begin
            // lowest free cell takes a new key
            valid_next     = 1'b1;
            address_next   = cmd.peer_address;
            port_next      = cmd.peer_port;
            direction_next = cmd.direction;
            present_next   = kind_mask;
            shares_next    = 12'd0;
            modes_next     = 3'b000;
            for (int k = 0; k < 3; k++)
            begin
                if (kind_mask[k])
                begin
                    shares_next[k*4 +: 4] = cmd.share_tenths;
                    modes_next[k]         = cmd.pick_mode;
                end
            end
            count_next = 4'd0;
        end
    end

    always_comb
    begin
        link_out.hit_seen  = link_in.hit_seen || key_match;
        link_out.free_seen = link_in.free_seen || !valid_reg;
        link_out.status    = hit ? my_status  : link_in.status;
        link_out.verdict   = hit ? my_verdict : link_in.verdict;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        address_reg   <= address_next;
        port_reg      <= port_next;
        direction_reg <= direction_next;
        present_reg   <= present_next;
        shares_reg    <= shares_next;
        modes_reg     <= modes_next;
        count_reg     <= count_next;
    end

endmodule

>>> rtl/ack_fault_injection_table.sv
// ----------------------------------------------------------------------------
// ack_fault_injection_table
// Fault-injection rule table for acks: add, remove, update and check rules
// keyed by peer address, peer port and direction.
// ----------------------------------------------------------------------------
//
//  channel   ports                 handshake
//  --------  --------------------  ------------------------------------------
//  command   cmd, start, busy      item taken at an edge with start && !busy
//  result    result, done          one-cycle strobe, no back-pressure
//
// - no item is taken while busy: the edge that takes the item loads the command
//   register, the next edge lets every cell act and loads the result register
// - the result shows in the cycle right after that edge, while the next item
//   may be taken
// - the cost of a cycle is set by the ripple through the row of cells
// - reset clears every entry's valid bit, busy and done; no clearing pass
// - done is never stalled: the receiver must take each result as it shows
//
module ack_fault_injection_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  afit_pkg::afit_item_t   cmd,
    output afit_pkg::afit_result_t result,
    output logic                   done
);
    import afit_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    afit_item_t   cmd_reg, cmd_next;
    afit_result_t result_reg, result_next;

    // the chain: links[i] enters cell i, links[TABLE_ENTRIES] leaves the last
    afit_link_t   links [TABLE_ENTRIES+1];
    logic         any_hit;
    logic         kind_ok;

    assign links[0] = '0;
    assign any_hit  = links[TABLE_ENTRIES].hit_seen;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            afit_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .eval     (busy_reg),
                .cmd      (cmd_reg),
                .any_hit  (any_hit),
                .link_in  (links[gi]),
                .link_out (links[gi+1])
            );
        end
    endgenerate

    // control: accept, then evaluate while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cmd_next  = cmd_reg;
        if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cmd_next  = cmd;
        end
    end

    // result: the hitting cell answers; with no hit the answer is made here
    always_comb
    begin
        kind_ok     = (cmd_reg.fault_kind <= KIND_HDR_MISMATCH);
        result_next = result_reg;
        if (busy_reg)
        begin
            result_next.verdict = VD_NONE;
            if (any_hit)
            begin
                result_next.status  = links[TABLE_ENTRIES].status;
                result_next.verdict = links[TABLE_ENTRIES].verdict;
            end
            else
            begin
                case (cmd_reg.opcode)
                    OP_ADD:
                    begin
                        if (!kind_ok)
                            result_next.status = ST_REJECT;
                        else if (!links[TABLE_ENTRIES].free_seen)
                            result_next.status = ST_FULL;
                        else
                            result_next.status = ST_DONE;
                    end
                    default:
                    begin
                        result_next.status = ST_NOT_FOUND;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/afit_checker.sv
// ----------------------------------------------------------------------------
// afit_checker
// Port-level timing checks for the rule table, bound to the top level.
// ----------------------------------------------------------------------------
module afit_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input afit_pkg::afit_result_t result,
    input logic                   done
);
    import afit_pkg::*;

    // a taken item makes the block busy for exactly one cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was taken");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // each taken item raises busy, then gives its result strobe
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result strobe missing after an item");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result strobe overlaps busy or repeats");

    // a fault verdict only comes with a successful check
    a_verdict_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.verdict == VD_NONE || result.status == ST_DONE))
        else $error("verdict reported with a failing status");

endmodule

bind ack_fault_injection_table afit_checker u_afit_checker (.*);

>>> tb/sv/ack_fault_injection_table_tb.sv
// ----------------------------------------------------------------------------
// ack_fault_injection_table_tb
// Self-checking bench for the ack fault-injection rule table. A behavioral
// copy of the table predicts status and verdict for every accepted item.
// The first tests walk add, update, check windows, remove and a full table;
// a long random run then mixes all four operations over a small key pool
// with random idle gaps.
// ----------------------------------------------------------------------------
module ack_fault_injection_table_tb;

    import afit_pkg::*;

    // kind code with no slot in an entry
    localparam logic [1:0] KIND_NO_SLOT = 2'd3;

    // keys that the stimulus draws from; more keys than entries so the table fills
    localparam int KEY_POOL     = 12;
    localparam int RANDOM_ITEMS = 1720;
    localparam int BLOCK_ITEMS  = 125;
    // cycles with neither an accepted item nor a result before giving up
    localparam int QUIET_LIMIT  = 1000;
    // cycles to let pass once nothing is awaited
    localparam int DRAIN_CYCLES = 8;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    afit_item_t   cmd;
    afit_result_t result;
    logic         done;

    ack_fault_injection_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .result (result),
        .done   (done)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // key pool
    // ------------------------------------------------------------------
    logic [31:0] key_addr [KEY_POOL];
    logic [15:0] key_port [KEY_POOL];
    logic        key_dir  [KEY_POOL];

    // ------------------------------------------------------------------
    // behavioral copy of the rule table
    // ------------------------------------------------------------------
    logic        rule_valid  [TABLE_ENTRIES];
    logic [31:0] rule_addr   [TABLE_ENTRIES];
    logic [15:0] rule_port   [TABLE_ENTRIES];
    logic        rule_dir    [TABLE_ENTRIES];
    logic [2:0]  rule_kinds  [TABLE_ENTRIES];
    logic [3:0]  rule_share  [TABLE_ENTRIES][3];
    logic [2:0]  rule_mode   [TABLE_ENTRIES];
    logic [3:0]  rule_visits [TABLE_ENTRIES];

    // verdict reported for each kind slot, in priority order
    afit_verdict_e kind_verdict [3] = '{VD_TIMEOUT, VD_EXCEPTION, VD_HDR_MISMATCH};

    // answers owed by the table, oldest first
    afit_result_t rule_answers_due [$];
    int           mismatch_count;
    int           quiet_cycles;

    // apply one command to the copy of the table and return its answer
    function automatic afit_result_t apply_rule_command(afit_item_t it);
        afit_result_t ans;
        int           hit;
        int           slot;
        int           total;
        int           base;
        int           visits;
        ans.status  = ST_DONE;
        ans.verdict = VD_NONE;
        hit   = -1;
        slot  = -1;
        total = 0;
        // scan downward so the lowest matching / free entry wins
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (rule_valid[i] && rule_addr[i] == it.peer_address &&
                rule_port[i] == it.peer_port && rule_dir[i] == it.direction)
                hit = i;
            if (!rule_valid[i])
                slot = i;
        end
        if (hit >= 0)
            for (int k = 0; k < 3; k++)
                if (rule_kinds[hit][k])
                    total += rule_share[hit][k];

        case (afit_op_e'(it.opcode))
            OP_CHECK:
            begin
                if (hit < 0)
                    ans.status = ST_NOT_FOUND;
                else
                begin
                    // windows are laid end to end in kind order, count taken before the step
                    visits = rule_visits[hit];
                    rule_visits[hit] = 4'((visits + 1) % SHARE_LIMIT);
                    base = 0;
                    for (int k = 0; k < 3; k++)
                        if (rule_kinds[hit][k])
                        begin
                            if (ans.verdict == VD_NONE && visits >= base &&
                                visits < base + rule_share[hit][k])
                                ans.verdict = kind_verdict[k];
                            base += rule_share[hit][k];
                        end
                end
            end
            OP_ADD:
            begin
                if (it.fault_kind > KIND_HDR_MISMATCH)
                    ans.status = ST_REJECT;
                else if (hit < 0)
                begin
                    if (slot < 0)
                        ans.status = ST_FULL;
                    else
                    begin
                        // a new entry takes any share, no limit check
                        rule_valid[slot]  = 1'b1;
                        rule_addr[slot]   = it.peer_address;
                        rule_port[slot]   = it.peer_port;
                        rule_dir[slot]    = it.direction;
                        rule_kinds[slot]  = '0;
                        rule_mode[slot]   = '0;
                        rule_visits[slot] = '0;
                        for (int k = 0; k < 3; k++)
                            rule_share[slot][k] = '0;
                        rule_kinds[slot][it.fault_kind] = 1'b1;
                        rule_share[slot][it.fault_kind] = it.share_tenths;
                        rule_mode[slot][it.fault_kind]  = it.pick_mode;
                    end
                end
                else if (rule_kinds[hit][it.fault_kind])
                    ans.status = ST_REJECT;
                else if (total + it.share_tenths >= SHARE_LIMIT)
                    ans.status = ST_REJECT;
                else
                begin
                    rule_kinds[hit][it.fault_kind] = 1'b1;
                    rule_share[hit][it.fault_kind] = it.share_tenths;
                    rule_mode[hit][it.fault_kind]  = it.pick_mode;
                end
            end
            OP_REMOVE:
            begin
                if (it.fault_kind > KIND_HDR_MISMATCH || hit < 0 ||
                    !rule_kinds[hit][it.fault_kind])
                    ans.status = ST_NOT_FOUND;
                else
                begin
                    rule_kinds[hit][it.fault_kind] = 1'b0;
                    // entry is freed with its last kind
                    if (rule_kinds[hit] == '0)
                        rule_valid[hit] = 1'b0;
                end
            end
            default:
            begin
                if (it.fault_kind > KIND_HDR_MISMATCH || hit < 0 ||
                    !rule_kinds[hit][it.fault_kind])
                    ans.status = ST_NOT_FOUND;
                else if (total - rule_share[hit][it.fault_kind] + it.share_tenths
                         >= SHARE_LIMIT)
                    ans.status = ST_REJECT;
                else
                begin
                    // the new share replaces the old one
                    rule_share[hit][it.fault_kind] = it.share_tenths;
                    rule_mode[hit][it.fault_kind]  = it.pick_mode;
                end
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic afit_item_t make_item(afit_op_e op, int key, logic [1:0] kind,
                                             logic [3:0] share, logic mode);
        afit_item_t it;
        it.opcode       = op;
        it.peer_address = key_addr[key];
        it.peer_port    = key_port[key];
        it.direction    = key_dir[key];
        it.fault_kind   = kind;
        it.share_tenths = share;
        it.pick_mode    = mode;
        return it;
    endfunction

    // drive at the falling edge, hold until the table takes it at a rising edge;
    // start stays high so a following item can go back to back
    task automatic send_item(input afit_item_t it);
        @(negedge clk);
        start = 1'b1;
        cmd   = it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rule_answers_due.push_back(apply_rule_command(it));
    endtask

    // drop start for some cycles; the payload carries junk meanwhile
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            cmd   = afit_item_t'({$urandom, 26'($urandom)});
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a check on an empty table finds nothing
    task automatic test_empty_table();
        send_item(make_item(OP_CHECK, 0, KIND_TIMEOUT, 4'd0, 1'b0));
    endtask

    // build one entry with all three kinds, hitting duplicate, limit and no-slot rejects
    task automatic test_add_rules();
        send_item(make_item(OP_ADD, 0, KIND_TIMEOUT, 4'd2, 1'b1));
        send_item(make_item(OP_ADD, 0, KIND_TIMEOUT, 4'd1, 1'b0));
        send_item(make_item(OP_ADD, 0, KIND_EXCEPTION, 4'd3, 1'b0));
        send_item(make_item(OP_ADD, 0, KIND_HDR_MISMATCH, 4'd5, 1'b1));
        send_item(make_item(OP_ADD, 0, KIND_HDR_MISMATCH, 4'd4, 1'b1));
        send_item(make_item(OP_ADD, 0, KIND_NO_SLOT, 4'd1, 1'b0));
    endtask

    // update over the limit is rejected, a legal one stores the new share
    task automatic test_update_rules();
        send_item(make_item(OP_UPDATE, 0, KIND_EXCEPTION, 4'd15, 1'b1));
        send_item(make_item(OP_UPDATE, 0, KIND_EXCEPTION, 4'd1, 1'b1));
    endtask

    // shares 2/1/4: two timeouts, one exception, four mismatches, then quiet
    task automatic test_check_windows();
        repeat (8)
            send_item(make_item(OP_CHECK, 0, KIND_TIMEOUT, 4'd0, 1'b0));
    endtask

    // strip the entry kind by kind; the last removal frees it
    task automatic test_remove_rules();
        send_item(make_item(OP_REMOVE, 0, KIND_NO_SLOT, 4'd0, 1'b0));
        send_item(make_item(OP_REMOVE, 0, KIND_TIMEOUT, 4'd0, 1'b0));
        send_item(make_item(OP_REMOVE, 0, KIND_EXCEPTION, 4'd0, 1'b0));
        send_item(make_item(OP_REMOVE, 0, KIND_HDR_MISMATCH, 4'd0, 1'b0));
        send_item(make_item(OP_CHECK, 0, KIND_TIMEOUT, 4'd0, 1'b0));
    endtask

    // fill every entry with full-scale shares, then one more key finds no room
    task automatic test_table_full();
        for (int i = 1; i <= TABLE_ENTRIES + 1; i++)
            send_item(make_item(OP_ADD, i, KIND_HDR_MISMATCH, 4'd15, 1'b1));
    endtask

    // blocks of random traffic; each block picks a key span and whether to idle
    task automatic test_random_traffic();
        afit_item_t it;
        afit_op_e   op;
        int         span;
        int         roll;
        bit         gaps_on;
        span    = KEY_POOL - 1;
        gaps_on = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BLOCK_ITEMS == 0)
            begin
                // narrow spans pile kinds onto few entries, wide ones keep the table full
                roll    = $urandom_range(0, 2);
                span    = (roll == 0) ? 3 : (roll == 1) ? 7 : KEY_POOL - 1;
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            op   = (roll < 40) ? OP_CHECK : (roll < 65) ? OP_ADD :
                   (roll < 80) ? OP_REMOVE : OP_UPDATE;
            it = make_item(op, $urandom_range(0, span),
                           ($urandom_range(0, 19) == 0) ? KIND_NO_SLOT :
                               2'($urandom_range(0, 2)),
                           ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4)) :
                               4'($urandom_range(0, 15)),
                           1'($urandom_range(0, 1)));
            // stray keys only on lookups, so they never take a slot for good
            if (op != OP_ADD && $urandom_range(0, 19) == 0)
            begin
                it.peer_address = $urandom;
                it.peer_port    = 16'($urandom);
                it.direction    = 1'($urandom);
            end
            send_item(it);
            if (gaps_on)
                hold_off(pick_gap());
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: every strobe must match the oldest owed answer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rule_answers_due.size() == 0)
            begin
                $display("%0t: result with nothing owed, status %0d verdict %0d",
                         $time, result.status, result.verdict);
                mismatch_count++;
            end
            else
            begin
                afit_result_t owed;
                owed = rule_answers_due.pop_front();
                if (result.status !== owed.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, owed.status, result.status);
                    mismatch_count++;
                end
                if (result.verdict !== owed.verdict)
                begin
                    $display("%0t: verdict expected %0d, got %0d",
                             $time, owed.verdict, result.verdict);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: nothing taken and nothing returned for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("ack_fault_injection_table_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            rule_valid[i]  = 1'b0;
            rule_addr[i]   = '0;
            rule_port[i]   = '0;
            rule_dir[i]    = 1'b0;
            rule_kinds[i]  = '0;
            rule_mode[i]   = '0;
            rule_visits[i] = '0;
            for (int k = 0; k < 3; k++)
                rule_share[i][k] = '0;
        end

        // key pool: field extremes, keys differing in one field only, random rest
        key_addr[0] = 32'h0000_0000;  key_port[0] = 16'h0000;  key_dir[0] = 1'b0;
        key_addr[1] = 32'hFFFF_FFFF;  key_port[1] = 16'hFFFF;  key_dir[1] = 1'b1;
        key_addr[2] = 32'hFFFF_FFFF;  key_port[2] = 16'hFFFF;  key_dir[2] = 1'b0;
        key_addr[3] = 32'hFFFF_FFFF;  key_port[3] = 16'h0000;  key_dir[3] = 1'b1;
        for (int i = 4; i < KEY_POOL; i++)
        begin
            key_addr[i] = $urandom;
            key_port[i] = 16'($urandom);
            key_dir[i]  = 1'($urandom);
        end
        // same address and port as its neighbor, other direction
        key_addr[5] = key_addr[4];
        key_port[5] = key_port[4];
        key_dir[5]  = ~key_dir[4];

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_add_rules();
        test_update_rules();
        test_check_windows();
        test_remove_rules();
        test_table_full();
        test_random_traffic();
        hold_off(1);

        // drain: the watchdog bounds this wait
        while (rule_answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("ack_fault_injection_table_tb: clean");
        else
            $display("ack_fault_injection_table_tb: errors");
        $finish;
    end

endmodule
